[design/gfmt_pkg.sv]
package gfmt_pkg;

	// Field widths of the request and response
	localparam int TIME_BITS = 24;
	localparam int GRAD_BITS = 16;
	localparam int MOM_W     = 64;

	// Shared multiplier: one 32-bit digit (plus sign) times a short operand
	localparam int DIG_W  = 32;
	localparam int MA_W   = DIG_W + 1;
	localparam int MB_W   = ((TIME_BITS > GRAD_BITS) ? TIME_BITS : GRAD_BITS) + 3;
	localparam int PROD_W = MA_W + MB_W;

	// Gradient sums: ga+gb, 3*(ga+gb), ga+2*gb
	localparam int SUM_W  = GRAD_BITS + 1;
	localparam int SUM3_W = GRAD_BITS + 3;
	localparam int G2_W   = GRAD_BITS + 2;

	// Three times the time since the epoch start
	localparam int D3_W = TIME_BITS + 2;

	// Accumulator wide enough for a whole segment or a whole report, unclamped
	localparam int ACC_SEG_W = 2 * TIME_BITS + GRAD_BITS + 6;
	localparam int ACC_RPT_W = TIME_BITS + MOM_W + 4;
	localparam int ACC_W     = (ACC_SEG_W > ACC_RPT_W) ? ACC_SEG_W : ACC_RPT_W;

	localparam int NUM_AXES = 3;

	typedef enum logic [1:0] {
		ACT_BREAK  = 2'd0,
		ACT_SAMPLE = 2'd1,
		ACT_RESET  = 2'd2,
		ACT_FLIP   = 2'd3
	} action_e;

	typedef struct packed {
		action_e                       action;
		logic        [TIME_BITS-1:0]   time_req;
		logic signed [GRAD_BITS-1:0]   grad_x;
		logic signed [GRAD_BITS-1:0]   grad_y;
		logic signed [GRAD_BITS-1:0]   grad_z;
	} req_t;

	typedef struct packed {
		logic        [TIME_BITS-1:0] report_time;
		logic signed [MOM_W-1:0]     moment_x;
		logic signed [MOM_W-1:0]     moment_y;
		logic signed [MOM_W-1:0]     moment_z;
	} rsp_t;

	// Micro-operation carried alongside each multiplier issue
	typedef enum logic [1:0] {
		OP_NONE,
		OP_PROD,
		OP_MAC,
		OP_FLUSH
	} op_e;

	typedef enum logic {
		BASE_ACC,
		BASE_SEED
	} base_e;

	typedef enum logic [2:0] {
		DST_ZACC,
		DST_FACC,
		DST_RES,
		DST_RH,
		DST_HH
	} dst_e;

	typedef struct packed {
		op_e        op;
		base_e      base;
		logic       neg;
		logic       hi;
		dst_e       dst;
		logic [1:0] axis;
	} tag_t;

	typedef struct packed {
		logic             valid;
		dst_e             dst;
		logic [1:0]       axis;
		logic [MOM_W-1:0] data;
	} wb_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_BP_RH,
		S_BP_HH,
		S_BP_AXIS,
		S_BP_FLUSH,
		S_RPT_AXIS,
		S_RPT_FLUSH,
		S_DRAIN,
		S_FIN
	} state_e;

endpackage

[design/gradient_first_moment_tracker.sv]
// Gradient first-moment tracker.
// Request channel (req_valid, req_stall, req): one point per request with its
// action, tick time and x/y/z gradient amplitudes, in time order. Response
// channel (rsp_valid, rsp_stall, rsp): one result for sample, reset and flip
// points, none for breakpoints; each carries the effective point time and six
// times the first moment per axis, clamped to 64 bits.
// One 33 x 27 bit multiplier with an accumulator does all arithmetic. A point
// that closes a segment of nonzero length costs 17 products (r*h, h*h, then
// five per axis); a report costs two products per axis. req_stall is high
// from acceptance until the sequencer is back in idle, and the next request
// is taken only in the idle state. A response waits in its output register
// while rsp_stall is high; the next request is still accepted, and only the
// final load of the following result waits for the register to free up.
// After reset the moments, times and gradients are zero, the sign is positive
// and the first point opens the epoch without integrating.
module gradient_first_moment_tracker
	import gfmt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [2:0] BP_SUB_LAST  = 3'd4;
	localparam logic [2:0] RPT_SUB_LAST = 3'd1;
	localparam logic [1:0] AXIS_LAST    = 2'(NUM_AXES - 1);

	state_e state_q, state_d;
	logic [2:0] sub_q;
	logic [1:0] axis_q;

	// Tracking state
	logic                          started_q;
	logic                          neg_q;
	logic        [TIME_BITS-1:0]   last_time_q;
	logic        [TIME_BITS-1:0]   epoch_q;
	logic signed [GRAD_BITS-1:0]   last_grad_q [NUM_AXES];
	logic signed [MOM_W-1:0]       zacc_q [NUM_AXES];
	logic signed [MOM_W-1:0]       facc_q [NUM_AXES];

	// Per-request working registers
	req_t                   in_q;
	logic [TIME_BITS-1:0]   t_q;
	logic [TIME_BITS-1:0]   h_q;
	logic [TIME_BITS-1:0]   r_q;
	logic [D3_W-1:0]        d3_q;
	logic signed [SUM_W-1:0]  sum_q  [NUM_AXES];
	logic signed [SUM3_W-1:0] sum3_q [NUM_AXES];
	logic signed [G2_W-1:0]   g2_q   [NUM_AXES];
	logic [MOM_W-1:0]       rh_q;
	logic [MOM_W-1:0]       hh_q;
	logic signed [MOM_W-1:0] res_q [NUM_AXES];

	rsp_t out_q;
	logic out_v_q;

	// Preparation terms
	logic signed [GRAD_BITS-1:0] g_in [NUM_AXES];
	logic [TIME_BITS-1:0] t_eff;
	logic [TIME_BITS-1:0] h_d;
	logic [TIME_BITS-1:0] epoch_d;
	logic [TIME_BITS-1:0] dt_d;
	logic                 do_report;
	logic                 load_out;
	logic                 accept;

	// Shared unit issue
	logic signed [MA_W-1:0]  op_a;
	logic signed [MB_W-1:0]  op_b;
	logic signed [MB_W-1:0]  d3_op;
	logic signed [MOM_W-1:0] seed;
	tag_t                    tag;
	wb_t                     wb;

	assign g_in[0] = in_q.grad_x;
	assign g_in[1] = in_q.grad_y;
	assign g_in[2] = in_q.grad_z;

	assign accept    = req_valid && !req_stall;
	assign do_report = (in_q.action == ACT_SAMPLE) || (in_q.action == ACT_FLIP);
	assign load_out  = (state_q == S_FIN) && (in_q.action != ACT_BREAK)
		&& !(out_v_q && rsp_stall);

	// Clamp time going backwards; the first point opens the epoch
	assign t_eff   = (started_q && (in_q.time_req < last_time_q)) ? last_time_q
		: in_q.time_req;
	assign h_d     = started_q ? (t_eff - last_time_q) : '0;
	assign epoch_d = started_q ? epoch_q : in_q.time_req;
	assign dt_d    = t_eff - epoch_d;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_PREP;
			end
			S_PREP: begin
				priority if (h_d != '0) state_d = S_BP_RH;
				else if (do_report)     state_d = S_RPT_AXIS;
				else                    state_d = S_FIN;
			end
			S_BP_RH: state_d = S_BP_HH;
			S_BP_HH: state_d = S_BP_AXIS;
			S_BP_AXIS: begin
				if (sub_q == BP_SUB_LAST && axis_q == AXIS_LAST) state_d = S_BP_FLUSH;
			end
			S_BP_FLUSH: state_d = do_report ? S_RPT_AXIS : S_DRAIN;
			S_RPT_AXIS: begin
				if (sub_q == RPT_SUB_LAST && axis_q == AXIS_LAST) state_d = S_RPT_FLUSH;
			end
			S_RPT_FLUSH: state_d = S_DRAIN;
			S_DRAIN:     state_d = S_FIN;
			S_FIN: begin
				if (in_q.action == ACT_BREAK || load_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Operand selection and micro-op for the shared unit
	assign d3_op = neg_q ? signed'(MB_W'(d3_q)) : -signed'(MB_W'(d3_q));

	always_comb begin
		op_a = '0;
		op_b = '0;
		seed = '0;
		tag  = '{op: OP_NONE, base: BASE_ACC, neg: 1'b0, hi: 1'b0,
			dst: DST_ZACC, axis: axis_q};
		req_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_BP_RH: begin
				op_a    = signed'(MA_W'(r_q));
				op_b    = signed'(MB_W'(h_q));
				tag.op  = OP_PROD;
				tag.dst = DST_RH;
			end
			S_BP_HH: begin
				op_a    = signed'(MA_W'(h_q));
				op_b    = signed'(MB_W'(h_q));
				tag.op  = OP_PROD;
				tag.dst = DST_HH;
			end
			S_BP_AXIS: begin
				tag.op = OP_MAC;
				unique case (sub_q)
					3'd0: begin
						op_a     = signed'(MA_W'(h_q));
						op_b     = MB_W'(sum_q[axis_q]);
						seed     = zacc_q[axis_q];
						tag.base = BASE_SEED;
						tag.dst  = DST_ZACC;
					end
					3'd1: begin
						op_a     = signed'(MA_W'(rh_q[DIG_W-1:0]));
						op_b     = MB_W'(sum3_q[axis_q]);
						seed     = facc_q[axis_q];
						tag.base = BASE_SEED;
						tag.dst  = DST_FACC;
					end
					3'd2: begin
						op_a   = signed'(MA_W'(rh_q[MOM_W-1:DIG_W]));
						op_b   = MB_W'(sum3_q[axis_q]);
						tag.hi = 1'b1;
					end
					3'd3: begin
						op_a = signed'(MA_W'(hh_q[DIG_W-1:0]));
						op_b = MB_W'(g2_q[axis_q]);
					end
					default: begin
						op_a   = signed'(MA_W'(hh_q[MOM_W-1:DIG_W]));
						op_b   = MB_W'(g2_q[axis_q]);
						tag.hi = 1'b1;
					end
				endcase
			end
			S_RPT_AXIS: begin
				tag.op = OP_MAC;
				op_b   = d3_op;
				if (sub_q == 3'd0) begin
					op_a     = signed'(MA_W'(zacc_q[axis_q][DIG_W-1:0]));
					seed     = facc_q[axis_q];
					tag.base = BASE_SEED;
					tag.neg  = neg_q;
					tag.dst  = DST_RES;
				end else begin
					op_a   = MA_W'(signed'(zacc_q[axis_q][MOM_W-1:DIG_W]));
					tag.hi = 1'b1;
				end
			end
			S_BP_FLUSH, S_RPT_FLUSH: begin
				tag.op = OP_FLUSH;
			end
			S_IDLE, S_PREP, S_DRAIN, S_FIN: begin
				tag.op = OP_NONE;
			end
			default: begin
				tag.op = OP_NONE;
			end
		endcase
	end

	gfmt_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op_a   (op_a),
		.op_b   (op_b),
		.seed   (seed),
		.tag    (tag),
		.wb     (wb)
	);

	// Sequencer and tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sub_q       <= '0;
			axis_q      <= '0;
			started_q   <= 1'b0;
			neg_q       <= 1'b0;
			out_v_q     <= 1'b0;
			last_time_q <= '0;
			epoch_q     <= '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				last_grad_q[i] <= '0;
				zacc_q[i]      <= '0;
				facc_q[i]      <= '0;
			end
		end else begin
			state_q <= state_d;

			// Advance the axis and step counters
			if (state_q == S_BP_AXIS || state_q == S_RPT_AXIS) begin
				if ((state_q == S_BP_AXIS && sub_q == BP_SUB_LAST)
					|| (state_q == S_RPT_AXIS && sub_q == RPT_SUB_LAST)) begin
					sub_q  <= '0;
					axis_q <= axis_q + 2'd1;
				end else begin
					sub_q <= sub_q + 3'd1;
				end
			end else begin
				sub_q  <= '0;
				axis_q <= '0;
			end

			// Take the point: time, epoch and gradients
			if (state_q == S_PREP) begin
				started_q   <= 1'b1;
				last_time_q <= t_eff;
				epoch_q     <= epoch_d;
				for (int i = 0; i < NUM_AXES; i++) begin
					last_grad_q[i] <= g_in[i];
				end
			end

			// Store closed moment chains
			if (wb.valid) begin
				unique case (wb.dst)
					DST_ZACC: zacc_q[wb.axis] <= wb.data;
					DST_FACC: facc_q[wb.axis] <= wb.data;
					default: ;
				endcase
			end

			// Apply reset or flip as the result goes out
			if (load_out) begin
				out_v_q <= 1'b1;
				if (in_q.action == ACT_RESET) begin
					epoch_q <= t_q;
					neg_q   <= 1'b0;
					for (int i = 0; i < NUM_AXES; i++) begin
						zacc_q[i] <= '0;
						facc_q[i] <= '0;
					end
				end else if (in_q.action == ACT_FLIP) begin
					neg_q <= ~neg_q;
				end
			end else if (out_v_q && !rsp_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= req;
		end

		if (state_q == S_PREP) begin
			t_q  <= t_eff;
			h_q  <= h_d;
			r_q  <= last_time_q - epoch_q;
			d3_q <= D3_W'(dt_d) + (D3_W'(dt_d) << 1);
			for (int i = 0; i < NUM_AXES; i++) begin
				sum_q[i]  <= SUM_W'(last_grad_q[i]) + SUM_W'(g_in[i]);
				sum3_q[i] <= SUM3_W'(last_grad_q[i]) + SUM3_W'(g_in[i])
					+ ((SUM3_W'(last_grad_q[i]) + SUM3_W'(g_in[i])) <<< 1);
				g2_q[i]   <= G2_W'(last_grad_q[i]) + (G2_W'(g_in[i]) <<< 1);
			end
		end

		if (wb.valid) begin
			unique case (wb.dst)
				DST_RES: res_q[wb.axis] <= wb.data;
				DST_RH:  rh_q <= wb.data;
				DST_HH:  hh_q <= wb.data;
				default: ;
			endcase
		end

		if (load_out) begin
			out_q.report_time <= t_q;
			if (in_q.action == ACT_RESET) begin
				out_q.moment_x <= '0;
				out_q.moment_y <= '0;
				out_q.moment_z <= '0;
			end else begin
				out_q.moment_x <= res_q[0];
				out_q.moment_y <= res_q[1];
				out_q.moment_z <= res_q[2];
			end
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	// A request always starts with the preparation step
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_PREP)
		else $error("accepted request did not enter preparation");

	// No write-back may land once the sequencer is idle or finishing
	a_quiet_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_FIN) |-> !wb.valid)
		else $error("write-back outside a computation");

	// A pending result holds the sequencer in the final step
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && in_q.action != ACT_BREAK && out_v_q && rsp_stall)
		|=> state_q == S_FIN && !req_stall == 1'b0)
		else $error("result dropped while response register busy");

	// Counters stay within the axis schedule
	a_counters: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BP_AXIS |-> sub_q <= BP_SUB_LAST && axis_q <= AXIS_LAST)
		else $error("integration step counter out of range");

	// A fresh result in the output register only appears on a load
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(load_out))
		else $error("response raised without a load");

endmodule

[design/gfmt_mac.sv]
module gfmt_mac
	import gfmt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [MA_W-1:0]  op_a,
	input  logic signed [MB_W-1:0]  op_b,
	input  logic signed [MOM_W-1:0] seed,
	input  tag_t                    tag,
	output wb_t                     wb
);

	localparam int SEED_W = MOM_W + 1;

	localparam logic [MOM_W-1:0] MOM_MAX = {1'b0, {(MOM_W-1){1'b1}}};
	localparam logic [MOM_W-1:0] MOM_MIN = {1'b1, {(MOM_W-1){1'b0}}};

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [SEED_W-1:0] seed_s1;
	tag_t                     tag_s1;

	logic signed [SEED_W-1:0] seed_ext;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  base_val;
	logic signed [ACC_W-1:0]  acc_d;
	logic signed [ACC_W-1:0]  acc_q;

	logic [ACC_W-MOM_W:0] acc_top;
	logic                 acc_fits;
	logic [MOM_W-1:0]     acc_sat;

	dst_e       dst_q;
	logic [1:0] dst_axis_q;
	logic       dst_v_q;

	// Widen the seed by one bit so that negation cannot overflow
	assign seed_ext = SEED_W'(seed);

	// Multiply stage: register product, seed and tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '{op: OP_NONE, base: BASE_ACC, neg: 1'b0, hi: 1'b0,
				dst: DST_ZACC, axis: 2'd0};
		end else begin
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		seed_s1 <= tag.neg ? -seed_ext : seed_ext;
	end

	// Accumulate stage: base plus product, upper digit shifted by one digit
	assign prod_ext = ACC_W'(prod_s1);
	assign addend   = tag_s1.hi ? (prod_ext <<< DIG_W) : prod_ext;
	assign base_val = (tag_s1.base == BASE_SEED) ? ACC_W'(seed_s1) : acc_q;
	assign acc_d    = base_val + addend;

	always_ff @(posedge clk) begin
		if (tag_s1.op == OP_MAC) begin
			acc_q <= acc_d;
		end
	end

	// Track where the running sum goes once its chain closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_q      <= DST_ZACC;
			dst_axis_q <= 2'd0;
			dst_v_q    <= 1'b0;
		end else begin
			if (tag_s1.op == OP_MAC && tag_s1.base == BASE_SEED) begin
				dst_q      <= tag_s1.dst;
				dst_axis_q <= tag_s1.axis;
				dst_v_q    <= 1'b1;
			end else if (tag_s1.op == OP_FLUSH) begin
				dst_v_q <= 1'b0;
			end
		end
	end

	// Clamp the running sum to the signed 64-bit range
	assign acc_top  = acc_q[ACC_W-1:MOM_W-1];
	assign acc_fits = (&acc_top) | ~(|acc_top);
	assign acc_sat  = acc_fits ? acc_q[MOM_W-1:0] : (acc_q[ACC_W-1] ? MOM_MIN : MOM_MAX);

	// Write back a raw product, or a closed chain when a new one opens or on a flush
	always_comb begin
		wb = '{valid: 1'b0, dst: dst_q, axis: dst_axis_q, data: acc_sat};
		unique case (tag_s1.op)
			OP_PROD: begin
				wb.valid = 1'b1;
				wb.dst   = tag_s1.dst;
				wb.axis  = tag_s1.axis;
				wb.data  = MOM_W'(prod_s1);
			end
			OP_MAC: begin
				wb.valid = dst_v_q && (tag_s1.base == BASE_SEED);
			end
			OP_FLUSH: begin
				wb.valid = dst_v_q;
			end
			OP_NONE: begin
				wb.valid = 1'b0;
			end
			default: begin
				wb.valid = 1'b0;
			end
		endcase
	end

endmodule
